[design/pcsc_pkg.sv]
// Package for the per-CPU scheduler clock: field widths, opcodes, register
// indexes, reset values, controller/datapath command and status structs, and
// signed-difference later/earlier helpers. No dependencies.
package pcsc_pkg;

    localparam int OP_W        = 2;
    localparam int CPU_W       = 3;
    localparam int NS_W        = 64;
    localparam int SCALE_W     = 20;
    localparam int PERIOD_W    = 30;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 30;
    localparam int HALF_W      = 32;
    localparam int PART_W      = HALF_W + SCALE_W;
    localparam int IDX_EXT_W   = 9;

    localparam int DEF_NUM_CPUS    = 8;
    localparam int DEF_SCALE_SHIFT = 10;

    localparam logic [SCALE_W-1:0]  SCALE_RST  = 20'd341;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 30'd1000000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_READ = 2'd1,
        OP_INIT = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE  = 2'd0,
        CFG_PERIOD = 2'd1,
        CFG_STABLE = 2'd2,
        CFG_UNUSED = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_ZERO,
        OUT_SCALED,
        OUT_T,
        OUT_RT
    } t_out_sel;

    typedef struct packed {
        logic     latch;
        logic     mul_lo;
        logic     mul_hi;
        logic     scale;
        logic     delta;
        logic     add;
        logic     clamp_lo;
        logic     clamp_hi;
        logic     cmp;
        logic     init;
        logic     wr_tick;
        logic     wr_own_t;
        logic     wr_own_rt;
        logic     wr_tgt_t;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic own_ok;
        logic tgt_ok;
        logic same_cpu;
        logic stable;
        logic running;
        logic rt_early;
    } t_status;

    // a is later than b when a - b is positive as a signed value
    function automatic logic [NS_W-1:0] later_of(input logic [NS_W-1:0] a,
                                                 input logic [NS_W-1:0] b);
        logic [NS_W-1:0] d;
        d = a - b;
        return (d != '0 && !d[NS_W-1]) ? a : b;
    endfunction

    function automatic logic [NS_W-1:0] earlier_of(input logic [NS_W-1:0] a,
                                                   input logic [NS_W-1:0] b);
        logic [NS_W-1:0] d;
        d = a - b;
        return d[NS_W-1] ? a : b;
    endfunction

endpackage

[design/pcsc_ctrl.sv]
// Controller for the per-CPU scheduler clock: sequences decode, scaling,
// clamp and write-back steps. Depends on pcsc_pkg.
module pcsc_ctrl
    import pcsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_LO,
        S_MUL_HI,
        S_SCALE,
        S_DELTA,
        S_ADD,
        S_CLAMP_LO,
        S_CLAMP_HI,
        S_CMP,
        S_WR_OWN,
        S_WR_TGT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.op)
                    OP_INIT: begin
                        o_cmd.init = 1'b1;
                        n_state    = S_IDLE;
                    end
                    OP_TICK: begin
                        if (i_status.stable || !i_status.running || !i_status.own_ok) begin
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_MUL_LO;
                        end
                    end
                    OP_READ: begin
                        if (i_status.stable) begin
                            n_state = S_MUL_LO;
                        end else if (!i_status.running || !i_status.own_ok ||
                                     !i_status.tgt_ok) begin
                            o_cmd.out_sel = OUT_ZERO;
                            n_state       = S_IDLE;
                        end else begin
                            n_state = S_MUL_LO;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_DELTA;
            end
            S_DELTA: begin
                // stable reads end here with the scaled counter
                if (i_status.stable) begin
                    o_cmd.out_sel = OUT_SCALED;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.delta = 1'b1;
                    n_state     = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CLAMP_LO;
            end
            S_CLAMP_LO: begin
                o_cmd.clamp_lo = 1'b1;
                n_state        = S_CLAMP_HI;
            end
            S_CLAMP_HI: begin
                o_cmd.clamp_hi = 1'b1;
                n_state        = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_WR_OWN;
            end
            S_WR_OWN: begin
                n_state = S_IDLE;
                if (i_status.op == OP_TICK) begin
                    o_cmd.wr_tick = 1'b1;
                end else if (i_status.same_cpu) begin
                    o_cmd.wr_own_t = 1'b1;
                    o_cmd.out_sel  = OUT_T;
                end else if (i_status.rt_early) begin
                    o_cmd.wr_own_t = 1'b1;
                    n_state        = S_WR_TGT;
                end else begin
                    o_cmd.wr_own_rt = 1'b1;
                    o_cmd.out_sel   = OUT_RT;
                end
            end
            S_WR_TGT: begin
                // raise the target clock to ours
                o_cmd.wr_tgt_t = 1'b1;
                o_cmd.out_sel  = OUT_T;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

[design/pcsc_datapath.sv]
// Datapath for the per-CPU scheduler clock: config registers, split counter
// multiply, per-CPU clock/anchor memories with valid bits, clamp logic.
// Depends on pcsc_pkg.
module pcsc_datapath
    import pcsc_pkg::*;
#(
    parameter int NUM_CPUS    = DEF_NUM_CPUS,
    parameter int SCALE_SHIFT = DEF_SCALE_SHIFT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [CPU_W-1:0]      i_own_cpu,
    input  logic [CPU_W-1:0]      i_target_cpu,
    input  logic [NS_W-1:0]       i_cpu_ticks,
    input  logic [NS_W-1:0]       i_sys_time_ns,
    output logic                  o_valid,
    output logic [NS_W-1:0]       o_clock_ns
);

    localparam int IW     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam logic [IDX_EXT_W-1:0] NCPU = IDX_EXT_W'(NUM_CPUS);

    // configuration
    logic [SCALE_W-1:0]  r_scale;
    logic [PERIOD_W-1:0] r_period;
    logic                r_stable;

    // block state outside the memories
    logic                r_running;
    logic [NS_W-1:0]     r_init_sys;
    logic [NUM_CPUS-1:0] r_v_anchor;
    logic [NUM_CPUS-1:0] r_v_clock;

    // latched transaction
    t_op                 r_op;
    logic [CPU_W-1:0]    r_own;
    logic [CPU_W-1:0]    r_tgt;
    logic [NS_W-1:0]     r_ticks;
    logic [NS_W-1:0]     r_sys;

    // memories
    logic [NS_W-1:0] mem_acnt [NUM_CPUS];
    logic [NS_W-1:0] mem_asys [NUM_CPUS];
    logic [NS_W-1:0] mem_clk  [NUM_CPUS];

    logic [NS_W-1:0] r_acnt_q, r_asys_q, r_own_clk_q, r_tgt_clk_q;
    logic            r_va_q, r_vc_own_q, r_vc_tgt_q;

    // arithmetic registers
    logic [PART_W-1:0] r_prod_lo;
    logic [HALF_W-1:0] r_prod_hi;
    logic [NS_W-1:0]   r_scaled, r_delta, r_hi_base, r_lo, r_hi, r_t;
    logic              r_rt_early;

    logic [IDX_EXT_W-1:0] own_ext, tgt_ext;
    logic [IW-1:0]        own_addr, tgt_addr;
    logic [NS_W-1:0]      acnt_eff, asys_eff, old_clk, rt_clk, delta_raw;
    logic [NS_W-1:0]      full_sum;
    logic [NS_W-1:0]      out_val;

    assign own_ext  = {{(IDX_EXT_W-CPU_W){1'b0}}, r_own};
    assign tgt_ext  = {{(IDX_EXT_W-CPU_W){1'b0}}, r_tgt};
    assign own_addr = own_ext[IW-1:0];
    assign tgt_addr = tgt_ext[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RST;
            r_period <= PERIOD_RST;
            r_stable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SCALE:  r_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_STABLE: r_stable <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= t_op'(i_opcode);
            r_own   <= i_own_cpu;
            r_tgt   <= i_target_cpu;
            r_ticks <= i_cpu_ticks;
            r_sys   <= i_sys_time_ns;
        end
    end

    // registered reads at the latched addresses, every cycle
    always_ff @(posedge i_clk) begin
        r_acnt_q    <= mem_acnt[own_addr];
        r_asys_q    <= mem_asys[own_addr];
        r_own_clk_q <= mem_clk[own_addr];
        r_tgt_clk_q <= mem_clk[tgt_addr];
        r_va_q      <= r_v_anchor[own_addr];
        r_vc_own_q  <= r_v_clock[own_addr];
        r_vc_tgt_q  <= r_v_clock[tgt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_tick) begin
            mem_acnt[own_addr] <= r_scaled;
            mem_asys[own_addr] <= r_sys;
        end
        if (i_cmd.wr_tick || i_cmd.wr_own_t) begin
            mem_clk[own_addr] <= r_t;
        end else if (i_cmd.wr_own_rt) begin
            mem_clk[own_addr] <= rt_clk;
        end else if (i_cmd.wr_tgt_t) begin
            mem_clk[tgt_addr] <= r_t;
        end
    end

    // entries not written since init read as the init values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_init_sys <= '0;
            r_v_anchor <= '0;
            r_v_clock  <= '0;
        end else if (i_cmd.init) begin
            r_running  <= 1'b1;
            r_init_sys <= r_sys;
            r_v_anchor <= '0;
            r_v_clock  <= '0;
        end else begin
            if (i_cmd.wr_tick) begin
                r_v_anchor[own_addr] <= 1'b1;
            end
            if (i_cmd.wr_tick || i_cmd.wr_own_t || i_cmd.wr_own_rt) begin
                r_v_clock[own_addr] <= 1'b1;
            end else if (i_cmd.wr_tgt_t) begin
                r_v_clock[tgt_addr] <= 1'b1;
            end
        end
    end

    // a tick re-anchors before the clock update
    always_comb begin
        if (r_op == OP_TICK) begin
            acnt_eff = r_scaled;
            asys_eff = r_sys;
        end else begin
            acnt_eff = r_va_q ? r_acnt_q : '0;
            asys_eff = r_va_q ? r_asys_q : r_init_sys;
        end
        old_clk   = r_vc_own_q ? r_own_clk_q : r_init_sys;
        rt_clk    = r_vc_tgt_q ? r_tgt_clk_q : r_init_sys;
        delta_raw = r_scaled - acnt_eff;
        // product wraps at 64 bits before the shift
        full_sum  = NS_W'(r_prod_lo) + {r_prod_hi, {HALF_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_prod_lo <= PART_W'(r_ticks[HALF_W-1:0] * r_scale);
        end
        if (i_cmd.mul_hi) begin
            r_prod_hi <= HALF_W'(r_ticks[NS_W-1:HALF_W] * r_scale);
        end
        if (i_cmd.scale) begin
            r_scaled <= full_sum >> SCALE_SHIFT;
        end
        if (i_cmd.delta) begin
            r_delta   <= delta_raw[NS_W-1] ? '0 : delta_raw;
            r_hi_base <= asys_eff + NS_W'(r_period);
            r_lo      <= later_of(asys_eff, old_clk);
        end
        if (i_cmd.add) begin
            r_t  <= asys_eff + r_delta;
            r_hi <= later_of(old_clk, r_hi_base);
        end else if (i_cmd.clamp_lo) begin
            r_t <= later_of(r_t, r_lo);
        end else if (i_cmd.clamp_hi) begin
            r_t <= earlier_of(r_t, r_hi);
        end
        if (i_cmd.cmp) begin
            r_rt_early <= (((rt_clk - r_t) >> (NS_W-1)) != '0);
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            OUT_SCALED: out_val = r_scaled;
            OUT_T:      out_val = r_t;
            OUT_RT:     out_val = rt_clk;
            default:    out_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (i_cmd.out_sel != OUT_NONE);
        end
        if (i_cmd.out_sel != OUT_NONE) begin
            o_clock_ns <= out_val;
        end
    end

    assign o_status.op       = r_op;
    assign o_status.own_ok   = own_ext < NCPU;
    assign o_status.tgt_ok   = tgt_ext < NCPU;
    assign o_status.same_cpu = (r_own == r_tgt);
    assign o_status.stable   = r_stable;
    assign o_status.running  = r_running;
    assign o_status.rt_early = r_rt_early;

endmodule

[design/per_cpu_sched_clock.sv]
// Per-CPU scheduler clock. A read strobes its result when its sequence ends,
// after an extra write step when the target clock is raised; a stable read
// ends after scaling, a rejected read right after decode. Busy stays high
// through each request, and the next start is taken as soon as busy drops.
// Scaling uses the two-pass 32x20 counter multiply, one 64-bit step per clamp;
// synchronous active-low reset sets config to defaults, clears running and valid bits.
module per_cpu_sched_clock
    import pcsc_pkg::*;
#(
    parameter int NUM_CPUS    = DEF_NUM_CPUS,
    parameter int SCALE_SHIFT = DEF_SCALE_SHIFT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [CPU_W-1:0]      i_own_cpu,
    input  logic [CPU_W-1:0]      i_target_cpu,
    input  logic [NS_W-1:0]       i_cpu_ticks,
    input  logic [NS_W-1:0]       i_sys_time_ns,
    output logic                  o_valid,
    output logic [NS_W-1:0]       o_clock_ns,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = !busy;

    pcsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start && !busy),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    pcsc_datapath #(
        .NUM_CPUS    (NUM_CPUS),
        .SCALE_SHIFT (SCALE_SHIFT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_own_cpu     (i_own_cpu),
        .i_target_cpu  (i_target_cpu),
        .i_cpu_ticks   (i_cpu_ticks),
        .i_sys_time_ns (i_sys_time_ns),
        .o_valid       (o_valid),
        .o_clock_ns    (o_clock_ns)
    );

endmodule

[tb/per_cpu_sched_clock_tb.sv]
// Testbench for per_cpu_sched_clock: a directed table, then random phases under
// several register settings, checked against an in-bench clock predictor or table values.
// Depends on pcsc_pkg and the per_cpu_sched_clock RTL.
`timescale 1ns / 1ps

module per_cpu_sched_clock_tb;
    import pcsc_pkg::*;

    localparam int NCPU          = DEF_NUM_CPUS;
    localparam int SHIFT         = DEF_SCALE_SHIFT;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 1000;
    localparam int PHASES        = 8;
    localparam int PER_PHASE     = 135;

    localparam logic [NS_W-1:0] ALL1 = '1;
    localparam logic [NS_W-1:0] MSB1 = 64'h8000_0000_0000_0000;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              cidx;
        logic [CFG_DATA_W-1:0] cdata;
        t_op                   op;
        logic [CPU_W-1:0]      own;
        logic [CPU_W-1:0]      tgt;
        logic [NS_W-1:0]       ticks;
        logic [NS_W-1:0]       sys;
        logic                  chk;
        logic [NS_W-1:0]       want;
    } t_dir_row;

    localparam t_dir_row DIRECTED [32] = '{
        // before init: read gives zero, tick and the unused opcode do nothing
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd0, 3'd1, ALL1, ALL1, 1'b1, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_TICK, 3'd2, 3'd2, ALL1, ALL1, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_NONE, 3'd5, 3'd6, ALL1, ALL1, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_INIT, 3'd0, 3'd0, ALL1, 64'd0, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd0, 3'd0, 64'd0, 64'd0, 1'b1, 64'd0},
        // counter at max pushes against the upper clamp
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd7, 3'd7, ALL1, 64'd0, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_TICK, 3'd3, 3'd3, 64'd3000, 64'd5000, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd3, 3'd0, 64'd6000, 64'd5000, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd0, 3'd3, 64'd12, 64'd5000, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd6, 3'd3, 64'd9000, 64'd0, 1'b0, 64'd0},
        // init at the top of the range, then wrap through zero
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_INIT, 3'd0, 3'd0, 64'd0, ALL1, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd1, 3'd2, ALL1, 64'd0, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_TICK, 3'd1, 3'd1, 64'd0, 64'd0, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd1, 3'd1, 64'd100, 64'd0, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd2, 3'd1, 64'd100000, 64'd0, 1'b0, 64'd0},
        // stable counter: reads give the scaled counter, tick is ignored
        '{ROW_CFG, CFG_STABLE, 30'd1, OP_NONE, 3'd0, 3'd0, 64'd0, 64'd0, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd0, 3'd5, 64'd0, 64'd0, 1'b1, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_TICK, 3'd0, 3'd0, 64'd5, 64'd5, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_INIT, 3'd0, 3'd0, 64'd0, 64'd1000, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd4, 3'd2, 64'd1024, 64'd0, 1'b1, 64'd341},
        '{ROW_CFG, CFG_SCALE, 30'd1024000, OP_NONE, 3'd0, 3'd0, 64'd0, 64'd0, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd3, 3'd3, ALL1, ALL1, 1'b0, 64'd0},
        '{ROW_CFG, CFG_SCALE, 30'd1, OP_NONE, 3'd0, 3'd0, 64'd0, 64'd0, 1'b0, 64'd0},
        '{ROW_CFG, CFG_PERIOD, 30'd1, OP_NONE, 3'd0, 3'd0, 64'd0, 64'd0, 1'b0, 64'd0},
        '{ROW_CFG, CFG_STABLE, 30'd0, OP_NONE, 3'd0, 3'd0, 64'd0, 64'd0, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd4, 3'd6, ALL1, 64'd0, 1'b0, 64'd0},
        // counter falls below its anchor: delta counts as zero
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_TICK, 3'd4, 3'd4, MSB1, MSB1, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd4, 3'd4, 64'd0, 64'd0, 1'b0, 64'd0},
        // write to the unused register index must change nothing
        '{ROW_CFG, CFG_UNUSED, 30'h3FFF_FFFF, OP_NONE, 3'd0, 3'd0, 64'd0, 64'd0, 1'b0, 64'd0},
        '{ROW_CFG, CFG_PERIOD, 30'd1000000000, OP_NONE, 3'd0, 3'd0, 64'd0, 64'd0, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd5, 3'd4, 64'd777777, 64'd0, 1'b0, 64'd0},
        '{ROW_ITEM, CFG_UNUSED, 30'd0, OP_READ, 3'd4, 3'd5, ALL1, ALL1, 1'b0, 64'd0}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  start         = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_opcode      = '0;
    logic [CPU_W-1:0]      i_own_cpu     = '0;
    logic [CPU_W-1:0]      i_target_cpu  = '0;
    logic [NS_W-1:0]       i_cpu_ticks   = '0;
    logic [NS_W-1:0]       i_sys_time_ns = '0;
    logic                  o_valid;
    logic [NS_W-1:0]       o_clock_ns;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // predictor copy of registers and per-CPU state
    logic [SCALE_W-1:0]  m_scale   = SCALE_RST;
    logic [PERIOD_W-1:0] m_period  = PERIOD_RST;
    logic                m_stable  = 1'b0;
    logic                m_running = 1'b0;
    logic [NS_W-1:0]     m_base_cnt [NCPU] = '{default: '0};
    logic [NS_W-1:0]     m_base_sys [NCPU] = '{default: '0};
    logic [NS_W-1:0]     m_clock    [NCPU] = '{default: '0};

    logic [NS_W-1:0] want_clock_q [$];
    int              mismatch_cnt  = 0;
    int              quiet_cycles  = 0;
    bit              gaps_on       = 1'b1;

    always #5 i_clk = ~i_clk;

    per_cpu_sched_clock dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_own_cpu     (i_own_cpu),
        .i_target_cpu  (i_target_cpu),
        .i_cpu_ticks   (i_cpu_ticks),
        .i_sys_time_ns (i_sys_time_ns),
        .o_valid       (o_valid),
        .o_clock_ns    (o_clock_ns),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    function automatic logic [NS_W-1:0] rand_ns();
        return {$urandom, $urandom};
    endfunction

    // counter to ns, product wraps at 64 bits before the shift
    function automatic logic [NS_W-1:0] scaled_counter_ns(input logic [NS_W-1:0] ticks);
        logic [NS_W-1:0] prod;
        prod = ticks * NS_W'(m_scale);
        return prod >> SHIFT;
    endfunction

    function automatic logic [NS_W-1:0] later_ns(input logic [NS_W-1:0] a,
                                                 input logic [NS_W-1:0] b);
        logic [NS_W-1:0] diff;
        diff = a - b;
        return ($signed(diff) > 0) ? a : b;
    endfunction

    function automatic logic [NS_W-1:0] earlier_ns(input logic [NS_W-1:0] a,
                                                   input logic [NS_W-1:0] b);
        logic [NS_W-1:0] diff;
        diff = a - b;
        return ($signed(diff) < 0) ? a : b;
    endfunction

    // advance one CPU clock from its counter, clamped between floor and ceiling
    function automatic logic [NS_W-1:0] refresh_cpu_clock(input logic [CPU_W-1:0] c,
                                                          input logic [NS_W-1:0] ticks);
        logic [NS_W-1:0] gain, prev, floor_ns, ceil_ns, t;
        gain = scaled_counter_ns(ticks) - m_base_cnt[c];
        if (gain[NS_W-1]) begin
            gain = '0;
        end
        prev     = m_clock[c];
        t        = m_base_sys[c] + gain;
        floor_ns = later_ns(m_base_sys[c], prev);
        ceil_ns  = later_ns(prev, m_base_sys[c] + NS_W'(m_period));
        t        = earlier_ns(later_ns(t, floor_ns), ceil_ns);
        m_clock[c] = t;
        return t;
    endfunction

    // CPU indexes are 3 bits wide with 8 CPUs, so they are never out of range
    task automatic predict_request(input t_op op, input logic [CPU_W-1:0] own,
                                   input logic [CPU_W-1:0] tgt,
                                   input logic [NS_W-1:0] ticks,
                                   input logic [NS_W-1:0] sys,
                                   output bit has_out, output logic [NS_W-1:0] value);
        logic [NS_W-1:0] own_ns, peer_ns;
        has_out = 1'b0;
        value   = '0;
        case (op)
            OP_INIT: begin
                for (int i = 0; i < NCPU; i++) begin
                    m_base_cnt[i] = '0;
                    m_base_sys[i] = sys;
                    m_clock[i]    = sys;
                end
                m_running = 1'b1;
            end
            OP_TICK: begin
                if (!m_stable && m_running) begin
                    m_base_cnt[own] = scaled_counter_ns(ticks);
                    m_base_sys[own] = sys;
                    void'(refresh_cpu_clock(own, ticks));
                end
            end
            OP_READ: begin
                has_out = 1'b1;
                if (m_stable) begin
                    value = scaled_counter_ns(ticks);
                end else if (m_running) begin
                    own_ns = refresh_cpu_clock(own, ticks);
                    value  = own_ns;
                    if (tgt != own) begin
                        // raise the lower of the own and target clocks to the higher
                        peer_ns = m_clock[tgt];
                        if ($signed(peer_ns - own_ns) < 0) begin
                            m_clock[tgt] = own_ns;
                        end else begin
                            m_clock[own] = peer_ns;
                            value        = peer_ns;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag_error(input string what, input logic [NS_W-1:0] want,
                              input logic [NS_W-1:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t %s: expected %h, got %h", $time, what, want, got);
        end
    endtask

    // hold the sender until every pending read has returned, then let the block go idle
    task automatic settle();
        start <= 1'b0;
        while (want_clock_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SCALE:  m_scale  = data[SCALE_W-1:0];
            CFG_PERIOD: m_period = data[PERIOD_W-1:0];
            CFG_STABLE: m_stable = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // start stays high on return so back-to-back requests need no drop
    task automatic send_request(input t_op op, input logic [CPU_W-1:0] own,
                                input logic [CPU_W-1:0] tgt,
                                input logic [NS_W-1:0] ticks,
                                input logic [NS_W-1:0] sys,
                                input bit typed, input logic [NS_W-1:0] typed_val);
        bit              has_out;
        logic [NS_W-1:0] value;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            pause_sender($urandom_range(1, 19));
        end
        start         <= 1'b1;
        i_opcode      <= op;
        i_own_cpu     <= own;
        i_target_cpu  <= tgt;
        i_cpu_ticks   <= ticks;
        i_sys_time_ns <= sys;
        do @(posedge i_clk); while (busy);
        predict_request(op, own, tgt, ticks, sys, has_out, value);
        if (has_out) begin
            want_clock_q.push_back(typed ? typed_val : value);
        end
    endtask

    always @(posedge i_clk) begin
        logic [NS_W-1:0] want;
        if (i_rst_n && o_valid) begin
            if (want_clock_q.size() == 0) begin
                flag_error("clock_ns with no read pending", '0, o_clock_ns);
            end else begin
                want = want_clock_q.pop_front();
                if (o_clock_ns !== want) begin
                    flag_error("clock_ns mismatch", want, o_clock_ns);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [NS_W-1:0]  wall;
        logic [NS_W-1:0]  cnt [NCPU];
        logic [NS_W-1:0]  ticks, sys;
        logic [CPU_W-1:0] own, tgt;
        t_op              op;
        int               r;
        logic [CFG_DATA_W-1:0] scale_val, period_val;
        logic             stable_val;

        wall = '0;
        foreach (cnt[i]) begin
            cnt[i] = '0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                cfg_write(DIRECTED[i].cidx, DIRECTED[i].cdata);
            end else begin
                send_request(DIRECTED[i].op, DIRECTED[i].own, DIRECTED[i].tgt,
                             DIRECTED[i].ticks, DIRECTED[i].sys,
                             DIRECTED[i].chk, DIRECTED[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    scale_val = 30'(SCALE_RST); period_val = 30'(PERIOD_RST); stable_val = 1'b0;
                end
                1: begin
                    scale_val = 30'd1; period_val = 30'd1; stable_val = 1'b0;
                end
                2: begin
                    scale_val = 30'd1024000; period_val = 30'd1000000000; stable_val = 1'b0;
                end
                3: begin
                    scale_val  = 30'($urandom_range(1, 1024000));
                    period_val = 30'($urandom_range(1, 1000000000));
                    stable_val = 1'b1;
                end
                default: begin
                    scale_val  = ($urandom_range(0, 3) == 0) ? 30'd1024000
                                                             : 30'($urandom_range(1, 1024000));
                    period_val = ($urandom_range(0, 3) == 0) ? 30'($urandom_range(1, 100))
                                                             : 30'($urandom_range(1, 1000000000));
                    stable_val = ($urandom_range(0, 4) == 0);
                end
            endcase
            cfg_write(CFG_SCALE, scale_val);
            cfg_write(CFG_PERIOD, period_val);
            cfg_write(CFG_STABLE, 30'(stable_val));
            if (ph == 2) begin
                cfg_write(CFG_UNUSED, 30'($urandom));
            end
            // last phase runs with no sender gaps at all
            gaps_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);

            for (int k = 0; k < PER_PHASE; k++) begin
                if (ph == 4 && k == PER_PHASE / 2) begin
                    settle();
                end
                r   = $urandom_range(0, 99);
                own = CPU_W'($urandom_range(0, NCPU - 1));
                tgt = ($urandom_range(0, 3) == 0) ? own : CPU_W'($urandom_range(0, NCPU - 1));
                if (k == 0 || r < 3) begin
                    op = OP_INIT;
                end else if (r < 5) begin
                    op = OP_NONE;
                end else if (r < 25) begin
                    op = OP_TICK;
                end else begin
                    op = OP_READ;
                end

                // well-formed traffic: system time and counters mostly move forward
                wall = wall + NS_W'($urandom_range(0, 3000));
                if ($urandom_range(0, 19) == 0) begin
                    cnt[own] = cnt[own] - NS_W'($urandom_range(0, 20000));
                end else begin
                    cnt[own] = cnt[own] + NS_W'($urandom_range(0, 9000));
                end
                if (op == OP_INIT) begin
                    if ($urandom_range(0, 3) == 0) begin
                        wall = rand_ns();
                    end
                    foreach (cnt[i]) begin
                        cnt[i] = NS_W'($urandom_range(0, 50000));
                    end
                end
                ticks = cnt[own];
                sys   = wall;
                if ($urandom_range(0, 11) == 0) begin
                    ticks = rand_ns();
                    sys   = rand_ns();
                end
                send_request(op, own, tgt, ticks, sys, 1'b0, '0);
            end
        end

        settle();
        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[per_cpu_sched_clock.f]
design/pcsc_pkg.sv
design/pcsc_ctrl.sv
design/pcsc_datapath.sv
design/per_cpu_sched_clock.sv
tb/per_cpu_sched_clock_tb.sv
